[sv/ean8_pkg.sv]
`default_nettype none

package ean8_pkg;

  localparam int COUNT_BITS  = 12;
  localparam int NUM_MODULES = 67;
  localparam int IDX_W       = $clog2(NUM_MODULES + 1);
  localparam int SPAN_W      = 13;
  localparam int CMP_W       = (COUNT_BITS > SPAN_W) ? COUNT_BITS + 1 : SPAN_W + 1;

  localparam int START_POS  = 0;
  localparam int LEFT_POS   = 3;
  localparam int CENTRE_POS = 31;
  localparam int RIGHT_POS  = 36;
  localparam int END_POS    = 64;
  localparam int DIGIT_LEN  = 7;

  localparam logic [2:0] SIDE_GUARD   = 3'b101;
  localparam logic [4:0] CENTRE_GUARD = 5'b01010;
  localparam logic [6:0] R_INVERT     = 7'h7F;

  localparam logic [6:0] LCODE [10] = '{
    7'h0D, 7'h19, 7'h13, 7'h3D, 7'h23, 7'h31, 7'h2F, 7'h3B, 7'h37, 7'h0B
  };

  // register word index on the APB port
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODULE = 2'd2;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_START   = 3'd1,
    ST_BAD_CENTRE  = 3'd2,
    ST_BAD_END     = 3'd3,
    ST_BAD_LEFT    = 3'd4,
    ST_BAD_RIGHT   = 3'd5,
    ST_TOO_NARROW  = 3'd6
  } status_e;

  typedef struct packed {
    logic [11:0] image_width;
    logic [11:0] image_height;
    logic [5:0]  module_width;
  } cfg_t;

  typedef struct packed {
    logic                   narrow;
    logic [NUM_MODULES-1:0] bits;
  } scan_t;

  typedef struct packed {
    logic  valid;
    scan_t scan;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    status_e         status;
    logic [7:0][3:0] digits;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] digit;
  } match_t;

  // bit at pos is the most significant bit of the group
  function automatic logic [6:0] group7(logic [NUM_MODULES-1:0] b, int pos);
    logic [6:0] v;
    v = '0;
    for (int i = 0; i < DIGIT_LEN; i++) begin
      v[DIGIT_LEN-1-i] = b[pos+i];
    end
    return v;
  endfunction

  function automatic match_t match_digit(logic [6:0] code, logic [6:0] invert);
    match_t m;
    m = '0;
    for (int d = 9; d >= 0; d--) begin
      if ((LCODE[d] ^ invert) == code) begin
        m.hit   = 1'b1;
        m.digit = 4'(d);
      end
    end
    return m;
  endfunction

  function automatic result_t decode_scan(scan_t s);
    result_t    r;
    logic       left_bad;
    logic       right_bad;
    match_t     m;
    logic [2:0] sg;
    logic [2:0] eg;
    logic [4:0] cg;
    r         = '0;
    left_bad  = 1'b0;
    right_bad = 1'b0;
    sg = {s.bits[START_POS], s.bits[START_POS+1], s.bits[START_POS+2]};
    eg = {s.bits[END_POS], s.bits[END_POS+1], s.bits[END_POS+2]};
    cg = {s.bits[CENTRE_POS], s.bits[CENTRE_POS+1], s.bits[CENTRE_POS+2],
          s.bits[CENTRE_POS+3], s.bits[CENTRE_POS+4]};
    for (int k = 0; k < 4; k++) begin
      m = match_digit(group7(s.bits, LEFT_POS + DIGIT_LEN * k), 7'h00);
      if (!m.hit) left_bad = 1'b1;
      r.digits[k] = m.digit;
    end
    for (int k = 0; k < 4; k++) begin
      m = match_digit(group7(s.bits, RIGHT_POS + DIGIT_LEN * k), R_INVERT);
      if (!m.hit) right_bad = 1'b1;
      r.digits[k+4] = m.digit;
    end
    if (s.narrow) r.status = ST_TOO_NARROW;
    else if (sg != SIDE_GUARD) r.status = ST_BAD_START;
    else if (cg != CENTRE_GUARD) r.status = ST_BAD_CENTRE;
    else if (eg != SIDE_GUARD) r.status = ST_BAD_END;
    else if (left_bad) r.status = ST_BAD_LEFT;
    else if (right_bad) r.status = ST_BAD_RIGHT;
    else r.status = ST_OK;
    if (r.status != ST_OK) r.digits = '0;
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/ean8_if.sv]
`default_nettype none

interface ean8_pixel_if;
  logic valid;
  logic ready;
  logic pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface ean8_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] digit_0;
  logic [3:0] digit_1;
  logic [3:0] digit_2;
  logic [3:0] digit_3;
  logic [3:0] digit_4;
  logic [3:0] digit_5;
  logic [3:0] digit_6;
  logic [3:0] digit_7;
  modport source (output valid, output status, output digit_0, output digit_1,
                  output digit_2, output digit_3, output digit_4, output digit_5,
                  output digit_6, output digit_7, input ready);
  modport sink (input valid, input status, input digit_0, input digit_1,
                input digit_2, input digit_3, input digit_4, input digit_5,
                input digit_6, input digit_7, output ready);
endinterface

`default_nettype wire

[sv/ean8_front.sv]
`default_nettype none

module ean8_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ean8_pkg::cfg_t cfg_i,
  input  wire logic          accept_i,
  input  wire logic          pixel_i,
  output ean8_pkg::push_t    push_o
);
  import ean8_pkg::*;

  logic [COUNT_BITS-1:0]  col_q, col_d, row_q, row_d;
  logic [5:0]             sum_q, sum_d, pim_q, pim_d;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [NUM_MODULES-1:0] bits_q, bits_d;

  logic [SPAN_W-1:0] span;
  logic [CMP_W-1:0]  margin, span_end;
  logic              narrow, mid_row, in_span, last_col, last_row;
  logic [5:0]        sum_e, pim_e, sum_n, pim_n;
  logic [IDX_W-1:0]  idx_e;

  assign span   = SPAN_W'(cfg_i.module_width) * SPAN_W'(NUM_MODULES);
  assign narrow = (cfg_i.module_width == '0) || (span > SPAN_W'(cfg_i.image_width));
  assign margin = CMP_W'((CMP_W'(cfg_i.image_width) - CMP_W'(span)) >> 1);
  assign span_end = margin + CMP_W'(span);

  assign mid_row  = CMP_W'(row_q) == CMP_W'(cfg_i.image_height >> 1);
  assign in_span  = (CMP_W'(col_q) >= margin) && (CMP_W'(col_q) < span_end);
  assign last_col = (CMP_W'(col_q) + CMP_W'(1)) >= CMP_W'(cfg_i.image_width);
  assign last_row = (CMP_W'(row_q) + CMP_W'(1)) >= CMP_W'(cfg_i.image_height);

  always_comb begin
    idx_e = idx_q;
    sum_e = sum_q;
    pim_e = pim_q;
    // module boundaries restart at column zero of the middle row
    if (mid_row && col_q == '0) begin
      idx_e = '0;
      sum_e = '0;
      pim_e = '0;
    end
    sum_n  = sum_e + 6'(pixel_i);
    pim_n  = pim_e + 6'd1;
    idx_d  = idx_e;
    sum_d  = sum_e;
    pim_d  = pim_e;
    bits_d = bits_q;
    if (mid_row && !narrow && in_span && idx_e < IDX_W'(NUM_MODULES)) begin
      if (pim_n >= cfg_i.module_width) begin
        bits_d[idx_e] = sum_n > (cfg_i.module_width >> 1);
        idx_d = idx_e + IDX_W'(1);
        sum_d = '0;
        pim_d = '0;
      end else begin
        sum_d = sum_n;
        pim_d = pim_n;
      end
    end
  end

  always_comb begin
    col_d = col_q + COUNT_BITS'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      sum_q <= '0;
      pim_q <= '0;
      idx_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
      sum_q <= sum_d;
      pim_q <= pim_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) bits_q <= bits_d;
  end

  // snapshot includes the module bit written by the closing pixel itself
  assign push_o.valid       = accept_i && last_col && last_row;
  assign push_o.scan.narrow = narrow;
  assign push_o.scan.bits   = bits_d;

endmodule

`default_nettype wire

[sv/ean8_queue.sv]
`default_nettype none

module ean8_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire ean8_pkg::push_t push_i,
  input  wire logic           pop_i,
  output ean8_pkg::scan_t     head_o,
  output ean8_pkg::qstat_t    stat_o
);
  import ean8_pkg::*;

  scan_t      entry_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i.valid) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i.valid) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) entry_q[wr_q] <= push_i.scan;
  end

  assign head_o       = entry_q[rd_q];
  assign stat_o.full  = cnt_q == 2'd2;
  assign stat_o.empty = cnt_q == 2'd0;

endmodule

`default_nettype wire

[sv/ean8_back.sv]
`default_nettype none

module ean8_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire ean8_pkg::scan_t  head_i,
  input  wire ean8_pkg::qstat_t stat_i,
  output logic                 pop_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output ean8_pkg::result_t    out_o
);
  import ean8_pkg::*;

  logic    valid_q;
  result_t res_q;

  // load whenever the output register is free or being drained
  assign pop_o = !stat_i.empty && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) res_q <= decode_scan(head_i);
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

`default_nettype wire

[sv/ean8_scanline_decoder.sv]
// EAN-8 scanline decoder: one pixel per cycle, raster order.
// Throughput: one pixel accepted every cycle; pixel ready drops only while
//   both result slots of the two-entry scan queue are taken.
// Result path: accepting the image's last pixel writes the scan queue; the decode
//   then loads the output register from it once that register is free or draining.
// Reset: asynchronous, active low; counters, queue and output valid clear,
//   registers return to width 67, height 1, module width 1.
`default_nettype none

module ean8_scanline_decoder (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  ean8_pixel_if.sink        pix_i,
  ean8_result_if.source     res_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import ean8_pkg::*;

  cfg_t    cfg_q;
  push_t   push;
  scan_t   head;
  qstat_t  qstat;
  logic    pop;
  logic    accept;
  logic    out_valid;
  result_t result;
  logic    cfg_wr;

  // Configuration registers: written on the access phase of an APB write.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width  <= 12'd67;
      cfg_q.image_height <= 12'd1;
      cfg_q.module_width <= 6'd1;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH:  cfg_q.image_width  <= pwdata[11:0];
        REG_HEIGHT: cfg_q.image_height <= pwdata[11:0];
        REG_MODULE: cfg_q.module_width <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {20'd0, cfg_q.image_width};
      REG_HEIGHT: prdata = {20'd0, cfg_q.image_height};
      REG_MODULE: prdata = {26'd0, cfg_q.module_width};
      default:    prdata = '0;
    endcase
  end

  // Front: hold pixels back only when the queue cannot take another scan.
  assign pix_i.ready = !qstat.full;
  assign accept      = pix_i.valid && pix_i.ready;

  ean8_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .accept_i (accept),
    .pixel_i  (pix_i.pixel),
    .push_o   (push)
  );

  // Queue: decouple pixel intake from result delivery.
  ean8_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (qstat)
  );

  // Back: guard checks and digit matching into the output register.
  ean8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .stat_i      (qstat),
    .pop_o       (pop),
    .out_ready_i (res_o.ready),
    .out_valid_o (out_valid),
    .out_o       (result)
  );

  assign res_o.valid   = out_valid;
  assign res_o.status  = result.status;
  assign res_o.digit_0 = result.digits[0];
  assign res_o.digit_1 = result.digits[1];
  assign res_o.digit_2 = result.digits[2];
  assign res_o.digit_3 = result.digits[3];
  assign res_o.digit_4 = result.digits[4];
  assign res_o.digit_5 = result.digits[5];
  assign res_o.digit_6 = result.digits[6];
  assign res_o.digit_7 = result.digits[7];

  // A scan is never pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !qstat.full)
    else $error("scan pushed into full queue");

  // Nothing is popped from an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

  // A failed decode carries all-zero digits.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && result.status != ST_OK) |-> (result.digits == '0))
    else $error("digits nonzero on error status");

  // A popped scan shows up as a valid result in the next cycle.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> out_valid)
    else $error("popped scan produced no result");

endmodule

`default_nettype wire

[test/tb.sv]
`default_nettype none

module tb;
  import ean8_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT    = 2_000_000;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned RANDOM_PIXELS  = 420;

  // L-set bar patterns, most significant bit is the leftmost module
  localparam bit [6:0] L_SET [10] = '{
    7'b0001101, 7'b0011001, 7'b0010011, 7'b0111101, 7'b0100011,
    7'b0110001, 7'b0101111, 7'b0111011, 7'b0110111, 7'b0001011
  };

  typedef enum {PAT_CODE, PAT_NOISE} pattern_e;

  // One directed image. Digits are packed digit_7 (top nibble) down to digit_0.
  typedef struct {
    int unsigned     w;
    int unsigned     h;
    int unsigned     mw;
    pattern_e        pat;
    logic [7:0][3:0] dg;
    int              flip;
    int unsigned     noise;
    bit              typed;
    status_e         exp_status;
    logic [7:0][3:0] exp_dg;
  } image_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ean8_pixel_if  pix_bus ();
  ean8_result_if res_bus ();

  ean8_scanline_decoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_bus),
    .res_o   (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Scan predictor: geometry registers and per-pixel state.
  int unsigned cfg_w;
  int unsigned cfg_h;
  int unsigned cfg_mw;
  int unsigned col_q;
  int unsigned row_q;
  int unsigned mod_sum;
  int unsigned mod_fill;
  int unsigned mod_idx;
  bit [0:66]   scan_bits;

  result_t     expected_results [$];
  result_t     typed_result;
  bit          typed_on = 1'b0;
  bit          steady = 1'b0;
  bit          hold_req = 1'b0;

  int unsigned pixels_sent = 0;
  int unsigned images_done = 0;
  int unsigned results_checked = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned geometry_phases = 0;
  int unsigned error_count = 0;
  int unsigned status_hits [7] = '{default: 0};

  // Directed images: reset geometry first, then every status and the odd geometries.
  image_row_t directed_rows [17] = '{
    // reset geometry, no register write
    '{67, 1, 1, PAT_CODE, 32'h0765_4321, -1, 0, 1'b1, ST_OK, 32'h0765_4321},
    // digit extremes 0 and 9
    '{67, 1, 1, PAT_CODE, 32'h9090_0909, -1, 0, 1'b1, ST_OK, 32'h9090_0909},
    // one broken module in each guard and each half
    '{67, 1, 1, PAT_CODE, 32'h1111_2222, 0, 0, 1'b1, ST_BAD_START, 32'h0},
    '{67, 1, 1, PAT_CODE, 32'h3333_4444, 32, 0, 1'b1, ST_BAD_CENTRE, 32'h0},
    '{67, 1, 1, PAT_CODE, 32'h5555_6666, 66, 0, 1'b1, ST_BAD_END, 32'h0},
    '{67, 1, 1, PAT_CODE, 32'h7777_8888, 10, 0, 1'b1, ST_BAD_LEFT, 32'h0},
    '{67, 1, 1, PAT_CODE, 32'h9999_0000, 50, 0, 1'b1, ST_BAD_RIGHT, 32'h0},
    // narrow by one pixel, zero module width, zero width, zero width and height
    '{66, 1, 1, PAT_NOISE, 32'h0, -1, 0, 1'b1, ST_TOO_NARROW, 32'h0},
    '{20, 2, 0, PAT_NOISE, 32'h0, -1, 0, 1'b1, ST_TOO_NARROW, 32'h0},
    '{0, 1, 1, PAT_NOISE, 32'h0, -1, 0, 1'b1, ST_TOO_NARROW, 32'h0},
    '{0, 0, 1, PAT_NOISE, 32'h0, -1, 0, 1'b1, ST_TOO_NARROW, 32'h0},
    // zero height reads row zero
    '{67, 0, 1, PAT_CODE, 32'h2468_1357, -1, 0, 1'b1, ST_OK, 32'h2468_1357},
    // stray pixels either side of the symbol, three rows
    '{69, 3, 1, PAT_CODE, 32'h8642_9753, -1, 0, 1'b0, ST_OK, 32'h0},
    // two-pixel modules, a whole stray module's worth of pixels on the right
    '{137, 1, 2, PAT_CODE, 32'h1029_3847, -1, 0, 1'b1, ST_OK, 32'h1029_3847},
    // all-ones module width can never fit
    '{67, 1, 63, PAT_NOISE, 32'h0, -1, 0, 1'b1, ST_TOO_NARROW, 32'h0},
    // majority vote under pixel noise, then a random module pattern
    '{201, 1, 3, PAT_CODE, 32'h5061_7283, -1, 10, 1'b0, ST_OK, 32'h0},
    '{67, 1, 1, PAT_NOISE, 32'h0, -1, 0, 1'b0, ST_OK, 32'h0}
  };

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Decode the latched module bits the way the block does at the end of an image.
  function automatic result_t decode_modules(input bit narrow);
    result_t  res;
    bit [6:0] grp;
    bit [6:0] flip_mask;
    int       hit;
    res = '0;
    res.status = ST_OK;
    if (narrow) begin
      res.status = ST_TOO_NARROW;
    end else if (scan_bits[START_POS +: 3] != SIDE_GUARD) begin
      res.status = ST_BAD_START;
    end else if (scan_bits[CENTRE_POS +: 5] != CENTRE_GUARD) begin
      res.status = ST_BAD_CENTRE;
    end else if (scan_bits[END_POS +: 3] != SIDE_GUARD) begin
      res.status = ST_BAD_END;
    end else begin
      for (int k = 0; k < 8; k++) begin
        if (res.status == ST_OK) begin
          if (k < 4) begin
            grp       = scan_bits[LEFT_POS + 7 * k +: 7];
            flip_mask = 7'h00;
          end else begin
            grp       = scan_bits[RIGHT_POS + 7 * (k - 4) +: 7];
            flip_mask = R_INVERT;
          end
          hit = -1;
          for (int d = 9; d >= 0; d--) begin
            if ((L_SET[d] ^ flip_mask) == grp) hit = d;
          end
          if (hit < 0) res.status = (k < 4) ? ST_BAD_LEFT : ST_BAD_RIGHT;
          else res.digits[k] = 4'(hit);
        end
      end
    end
    if (res.status != ST_OK) res.digits = '0;
    return res;
  endfunction

  // Advance the scan by one pixel; returns 1 when the pixel closes an image.
  function automatic bit scan_pixel(input bit px, output result_t res);
    int unsigned span;
    int unsigned margin;
    bit          narrow;
    bit          at_end;
    narrow = (cfg_mw == 0) || (cfg_mw * NUM_MODULES > cfg_w);
    res = '0;
    if (row_q == cfg_h / 2) begin
      if (col_q == 0) begin
        mod_idx  = 0;
        mod_sum  = 0;
        mod_fill = 0;
      end
      if (!narrow) begin
        span   = cfg_mw * NUM_MODULES;
        margin = (cfg_w - span) / 2;
        if (col_q >= margin && col_q < margin + span && mod_idx < NUM_MODULES) begin
          mod_sum  = (mod_sum + px) & 'h3F;
          mod_fill = (mod_fill + 1) & 'h3F;
          if (mod_fill >= cfg_mw) begin
            scan_bits[mod_idx] = (mod_sum > cfg_mw / 2);
            mod_idx++;
            mod_sum  = 0;
            mod_fill = 0;
          end
        end
      end
    end
    at_end = (col_q + 1 >= cfg_w) && (row_q + 1 >= cfg_h);
    if (at_end) begin
      res   = decode_modules(narrow);
      col_q = 0;
      row_q = 0;
    end else if (col_q + 1 >= cfg_w) begin
      col_q = 0;
      row_q = (row_q + 1) & 'hFFF;
    end else begin
      col_q = (col_q + 1) & 'hFFF;
    end
    return at_end;
  endfunction

  // Build the 67 module bits of a symbol from eight digits.
  function automatic bit [0:66] encode_digits(input logic [7:0][3:0] dg);
    bit [0:66] m;
    m = '0;
    m[START_POS +: 3]  = SIDE_GUARD;
    m[CENTRE_POS +: 5] = CENTRE_GUARD;
    m[END_POS +: 3]    = SIDE_GUARD;
    for (int k = 0; k < 4; k++) begin
      m[LEFT_POS + 7 * k +: 7]  = L_SET[dg[k]];
      m[RIGHT_POS + 7 * k +: 7] = L_SET[dg[k + 4]] ^ R_INVERT;
    end
    return m;
  endfunction

  // Offer one pixel, hold it until taken, then log the expected result.
  task automatic send_pixel(input bit px);
    result_t     predicted;
    int unsigned gap;
    int unsigned pick;
    pix_bus.valid <= 1'b1;
    pix_bus.pixel <= px;
    @(posedge clk_i);
    while (pix_bus.ready !== 1'b1) begin
      input_stall_cycles++;
      @(posedge clk_i);
    end
    pixels_sent++;
    if (scan_pixel(px, predicted)) begin
      expected_results.push_back(typed_on ? typed_result : predicted);
      images_done++;
    end
    gap = 0;
    if (!steady) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) gap = $urandom_range(8, 40);
      else if (pick < 16) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      pix_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stream one whole image in raster order. Only the middle row carries the symbol.
  task automatic send_image(input int unsigned w, input int unsigned h, input int unsigned mw,
                            input bit [0:66] code, input int unsigned noise);
    int unsigned ew;
    int unsigned eh;
    int unsigned span;
    int unsigned margin;
    bit          narrow;
    bit          px;
    ew     = (w == 0) ? 1 : w;
    eh     = (h == 0) ? 1 : h;
    narrow = (mw == 0) || (mw * NUM_MODULES > w);
    span   = mw * NUM_MODULES;
    margin = narrow ? 0 : (w - span) / 2;
    for (int unsigned r = 0; r < eh; r++) begin
      for (int unsigned c = 0; c < ew; c++) begin
        if (r == h / 2 && !narrow && c >= margin && c < margin + span) begin
          px = code[(c - margin) / mw];
          if ($urandom_range(0, 99) < noise) px = ~px;
        end else begin
          px = $urandom_range(0, 1);
        end
        send_pixel(px);
      end
    end
  endtask

  // Drop the request and hold until every expected result is back.
  task automatic drain();
    pix_bus.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (pready !== 1'b1) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_w  = value & 'hFFF;
      REG_HEIGHT: cfg_h  = value & 'hFFF;
      REG_MODULE: cfg_mw = value & 'h3F;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Reprogram geometry only with the block idle.
  task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned mw);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MODULE, mw);
    geometry_phases++;
  endtask

  task automatic check_result();
    result_t    want;
    logic [3:0] got [8];
    got = '{res_bus.digit_0, res_bus.digit_1, res_bus.digit_2, res_bus.digit_3,
            res_bus.digit_4, res_bus.digit_5, res_bus.digit_6, res_bus.digit_7};
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: status %0d", res_bus.status);
      error_count++;
    end else begin
      want = expected_results.pop_front();
      results_checked++;
      status_hits[want.status]++;
      if (res_bus.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, res_bus.status);
        error_count++;
      end
      for (int k = 0; k < 8; k++) begin
        if (got[k] !== want.digits[k]) begin
          $error("digit_%0d: expected %0d, got %0d", k, want.digits[k], got[k]);
          error_count++;
        end
      end
    end
  endtask

  // Result side: check every accepted result, stall at random, honor a long hold-off.
  initial begin
    int unsigned stall_left;
    int unsigned pick;
    stall_left = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
        check_result();
      end
      if (hold_req) begin
        stall_left = HOLD_CYCLES;
        hold_req   = 1'b0;
      end
      if (stall_left > 0) begin
        stall_left--;
        res_bus.ready <= 1'b0;
      end else begin
        pick = $urandom_range(0, 99);
        if (!steady && pick < 12) begin
          stall_left = (pick < 2) ? $urandom_range(10, 60) : $urandom_range(0, 3);
          res_bus.ready <= 1'b0;
        end else begin
          res_bus.ready <= 1'b1;
        end
      end
    end
  end

  // Watchdog: a missing result or a stuck handshake ends here.
  initial begin
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    image_row_t      row;
    bit [0:66]       code;
    logic [7:0][3:0] dg;
    int unsigned     base_pixels;
    int unsigned     g_w;
    int unsigned     g_h;
    int unsigned     g_mw;
    int unsigned     n_img;
    int unsigned     noise;
    int unsigned     pick;

    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    pix_bus.valid <= 1'b0;
    pix_bus.pixel <= 1'b0;
    rst_ni        <= 1'b0;

    // predictor starts from the reset geometry
    cfg_w     = 67;
    cfg_h     = 1;
    cfg_mw    = 1;
    col_q     = 0;
    row_q     = 0;
    mod_sum   = 0;
    mod_fill  = 0;
    mod_idx   = 0;
    scan_bits = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed images; rewrite geometry only when a row asks for a new one.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.w != cfg_w || row.h != cfg_h || row.mw != cfg_mw) begin
        set_geometry(row.w, row.h, row.mw);
      end
      // stream the three-row image back to back on both sides
      steady = (row.h > 2);
      typed_on            = row.typed;
      typed_result.status = row.exp_status;
      typed_result.digits = row.exp_dg;
      if (row.pat == PAT_CODE) begin
        code = encode_digits(row.dg);
      end else begin
        for (int j = 0; j < NUM_MODULES; j++) code[j] = $urandom_range(0, 1);
      end
      if (row.flip >= 0) code[row.flip] = ~code[row.flip];
      send_image(row.w, row.h, row.mw, code, row.noise);
    end
    typed_on = 1'b0;

    // One-pixel images close a result on every pixel: hold the result side off
    // while pixels keep coming, so the block backs up and stalls its input.
    set_geometry(1, 1, 1);
    steady   = 1'b1;
    hold_req = 1'b1;
    repeat (80) send_pixel($urandom_range(0, 1));

    // Random phases: mostly well-formed symbols at small sizes, some broken ones.
    base_pixels = pixels_sent;
    while (pixels_sent - base_pixels < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // narrow whatever the module width
        g_mw  = $urandom_range(0, 6);
        g_w   = $urandom_range(0, 66);
        g_h   = $urandom_range(0, 2);
        n_img = $urandom_range(1, 3);
      end else if (pick < 18) begin
        g_mw  = $urandom_range(4, 5);
        g_w   = 67 * g_mw + $urandom_range(0, 8);
        g_h   = 1;
        n_img = 1;
      end else begin
        g_mw  = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(2, 3);
        g_w   = 67 * g_mw + $urandom_range(0, 13);
        g_h   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 1;
        n_img = $urandom_range(1, 3);
      end
      set_geometry(g_w, g_h, g_mw);
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 19) == 0) hold_req = 1'b1;

      for (int unsigned n = 0; n < n_img && pixels_sent - base_pixels < RANDOM_PIXELS; n++) begin
        for (int k = 0; k < 8; k++) dg[k] = $urandom_range(0, 9);
        code  = encode_digits(dg);
        noise = 0;
        pick  = $urandom_range(0, 99);
        if (pick < 70) begin
          if (g_mw >= 3) noise = $urandom_range(0, 12);
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 2)) begin
            g_h = $urandom_range(0, NUM_MODULES - 1);
            code[g_h] = ~code[g_h];
          end
          g_h = cfg_h;
        end else if (pick < 92) begin
          noise = $urandom_range(1, 5);
        end else begin
          for (int j = 0; j < NUM_MODULES; j++) code[j] = $urandom_range(0, 1);
        end
        send_image(cfg_w, cfg_h, cfg_mw, code, noise);
        // now and then pause the pixel side until every result is back
        if (n + 1 < n_img && $urandom_range(0, 5) == 0) drain();
      end
    end

    steady = 1'b0;
    drain();

    $display("Streamed %0d pixels over %0d images in %0d geometries; pixel input stalled %0d cycles.",
             pixels_sent, images_done, geometry_phases, input_stall_cycles);
    $display("Checked %0d results: %0d decoded, %0d guard faults, %0d code faults, %0d narrow.",
             results_checked, status_hits[ST_OK],
             status_hits[ST_BAD_START] + status_hits[ST_BAD_CENTRE] + status_hits[ST_BAD_END],
             status_hits[ST_BAD_LEFT] + status_hits[ST_BAD_RIGHT], status_hits[ST_TOO_NARROW]);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
